[rtl/mvsm_pkg.sv]
// ---------------------------------------------------------------------------
// mvsm_pkg
// Shared types and constants of the multi-voice sample mixer.
// ---------------------------------------------------------------------------
package mvsm_pkg;

  localparam int MaxTracks   = 16;
  localparam int MaxChannels = 8;
  localparam int MemDepth    = 65536;
  localparam int TrkW        = $clog2(MaxTracks);
  localparam int ChW         = $clog2(MaxChannels);
  localparam int AddrW       = $clog2(MemDepth);

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_PLAY = 2'd1;
  localparam logic [1:0] ACT_MIX  = 2'd2;

  localparam logic [0:0] REG_OUT_CHANNELS = 1'b0;
  localparam logic [0:0] REG_TRACKS       = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [15:0]        mem_addr;
    logic signed [15:0] sample_value;
    logic [15:0]        sound_base;
    logic [3:0]         sound_channels;
    logic [15:0]        sound_frames;
  } in_word_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] mixed_sample;
    logic [2:0]         channel_index;
    logic               last_of_frame;
    logic               play_accepted;
    logic [3:0]         track_index;
  } out_word_t;

  // Track descriptor held in the track memory
  typedef struct packed {
    logic [15:0] base;
    logic [3:0]  chans;
    logic [15:0] length;
    logic [15:0] position;
  } track_t;

endpackage

[rtl/multi_voice_sample_mixer.sv]
// A mix is paced by the single sample memory read port, and an output stall
// holds the sequencer. One word is in flight at a time; the next is taken the cycle
// after the last result leaves. Reset (synchronous) frees all tracks and loads
// output_channels 2, tracks_in_use 16; sample memory is kept.
// ---------------------------------------------------------------------------
// multi_voice_sample_mixer
// Sample playback mixer with a track table memory and a sample memory.
// ---------------------------------------------------------------------------
module multi_voice_sample_mixer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mvsm_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mvsm_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data
);
  import mvsm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PSCAN, S_PRD, S_MTRK, S_MRD, S_MSMP, S_MACC, S_MNEXT,
    S_MOUT, S_ADV, S_ADVWR, S_OUT
  } state_t;

  state_t state;
  logic [3:0] out_channels;
  logic [4:0] tracks_in_use;
  logic [MaxTracks-1:0] active;

  // Memories
  logic signed [15:0] smem [MemDepth];
  track_t             tmem [MaxTracks];
  logic signed [15:0] smem_q;
  track_t             tmem_q;
  logic [AddrW-1:0]   s_raddr;
  logic [TrkW-1:0]    t_raddr;

  in_word_t    req;
  logic [TrkW:0]  trk;
  logic [ChW:0]   ch;
  logic [ChW:0]   nch;
  logic [TrkW:0]  ntr;
  logic signed [19+TrkW:0] acc [MaxChannels];
  logic [AddrW-1:0] start;
  logic [3:0]      cmod;
  out_word_t       obuf;

  assign ntr = (tracks_in_use > 5'(MaxTracks)) ? (TrkW+1)'(MaxTracks)
                                               : (TrkW+1)'(tracks_in_use);
  assign nch = (out_channels == 4'd0) ? (ChW+1)'(1)
             : (out_channels > 4'(MaxChannels)) ? (ChW+1)'(MaxChannels)
             : (ChW+1)'(out_channels);
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_data  = obuf;

  // Sample memory: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && in_data.action == ACT_LOAD)
      smem[in_data.mem_addr[AddrW-1:0]] <= in_data.sample_value;
    smem_q <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    tmem_q <= tmem[t_raddr];
  end

  // Saturate the current channel sum
  logic signed [15:0] sat;
  always_comb begin
    if (acc[ch[ChW-1:0]] > 32767) sat = 16'sh7fff;
    else if (acc[ch[ChW-1:0]] < -32768) sat = -16'sh8000;
    else sat = acc[ch[ChW-1:0]][15:0];
  end

  // Sequencer: walks tracks and channels through the memories
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_channels <= 4'd2;
      tracks_in_use <= 5'd16;
      active <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_OUT_CHANNELS: out_channels <= cfg_data[3:0];
          REG_TRACKS:       tracks_in_use <= cfg_data[4:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req <= in_data;
            trk <= '0;
            ch  <= '0;
            if (in_data.action == ACT_PLAY) state <= S_PSCAN;
            else if (in_data.action == ACT_MIX) begin
              for (int c = 0; c < MaxChannels; c++) acc[c] <= '0;
              state <= S_MTRK;
            end
          end
        end
        // Find the lowest free track
        S_PSCAN: begin
          if (trk >= ntr) begin
            obuf <= '0;
            state <= S_OUT;
          end else if (!active[trk[TrkW-1:0]]) begin
            tmem[trk[TrkW-1:0]] <= '{base: req.sound_base,
              chans: (req.sound_channels == 4'd0) ? 4'd1 : req.sound_channels,
              length: req.sound_frames, position: 16'd0};
            active[trk[TrkW-1:0]] <= 1'b1;
            obuf <= '{kind: 1'b0, mixed_sample: 16'sd0, channel_index: 3'd0,
                      last_of_frame: 1'b0, play_accepted: 1'b1,
                      track_index: 4'(trk[TrkW-1:0])};
            state <= S_OUT;
          end else begin
            trk <= trk + 1'b1;
          end
        end
        S_PRD: state <= S_IDLE;
        // Mix: per track, read descriptor then one sample per channel
        S_MTRK: begin
          if (trk >= ntr) begin
            trk <= '0;
            ch <= '0;
            state <= S_MOUT;
          end else if (!active[trk[TrkW-1:0]]) begin
            trk <= trk + 1'b1;
          end else begin
            t_raddr <= trk[TrkW-1:0];
            state <= S_MRD;
          end
        end
        S_MRD: state <= S_MSMP;
        S_MSMP: begin
          start <= AddrW'(tmem_q.base + tmem_q.chans * tmem_q.position);
          cmod <= 4'd0;
          ch <= '0;
          state <= S_MACC;
        end
        S_MACC: begin
          s_raddr <= start + AddrW'(cmod);
          state <= S_MNEXT;
        end
        S_MNEXT: state <= S_ADVWR;
        S_ADVWR: begin
          acc[ch[ChW-1:0]] <= acc[ch[ChW-1:0]] + smem_q;
          cmod <= (cmod + 4'd1 == tmem_q.chans) ? 4'd0 : cmod + 4'd1;
          if (ch + 1'b1 == nch) begin
            // Advance this track one frame
            if (17'(tmem_q.position) + 17'd1 >= 17'(tmem_q.length)) begin
              active[trk[TrkW-1:0]] <= 1'b0;
              tmem[trk[TrkW-1:0]] <= '{tmem_q.base, tmem_q.chans, tmem_q.length, 16'd0};
            end else begin
              tmem[trk[TrkW-1:0]] <= '{tmem_q.base, tmem_q.chans, tmem_q.length,
                                       tmem_q.position + 16'd1};
            end
            trk <= trk + 1'b1;
            state <= S_MTRK;
          end else begin
            ch <= ch + 1'b1;
            state <= S_MACC;
          end
        end
        // Emit one word per output channel
        S_MOUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            obuf <= '{kind: 1'b1, mixed_sample: sat, channel_index: 3'(ch),
                      last_of_frame: (ch + 1'b1 == nch), play_accepted: 1'b0,
                      track_index: 4'd0};
            if (ch + 1'b1 == nch) state <= S_ADV;
            else ch <= ch + 1'b1;
          end
        end
        S_ADV: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_ADV;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/mvsm_checker.sv]
// ---------------------------------------------------------------------------
// mvsm_checker
// Watches the input, output and register channels of the sample mixer,
// predicts every result word from its own track table and sample memory,
// and compares each output word field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module mvsm_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  mvsm_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  mvsm_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import mvsm_pkg::*;

  logic [3:0]  chan_cfg;
  logic [4:0]  trk_cfg;
  logic        act   [MaxTracks];
  logic [15:0] base  [MaxTracks];
  logic [3:0]  chans [MaxTracks];
  logic [15:0] len   [MaxTracks];
  logic [15:0] pos   [MaxTracks];
  logic [15:0] smem  [int];
  out_word_t   mix_expected[$];

  function automatic int sample_at(int unsigned a);
    logic [15:0] w;
    w = smem.exists(a % MemDepth) ? smem[a % MemDepth] : 16'h0;
    return $signed(w);
  endfunction

  // Work out the result words of one accepted input word
  task automatic predict_word(in_word_t w);
    int unsigned ntr, nch, tc, start;
    int acc[8];
    out_word_t r;
    int t;
    ntr = (trk_cfg > MaxTracks) ? MaxTracks : trk_cfg;
    nch = (chan_cfg < 1) ? 1 : chan_cfg;
    if (nch > MaxChannels) nch = MaxChannels;
    case (w.action)
      ACT_LOAD: smem[w.mem_addr] = w.sample_value;
      ACT_PLAY: begin
        r = '0;
        for (t = 0; t < ntr; t++) if (!act[t]) break;
        if (t < ntr) begin
          act[t] = 1'b1;
          base[t] = w.sound_base;
          chans[t] = (w.sound_channels == 0) ? 4'd1 : w.sound_channels;
          len[t] = w.sound_frames;
          pos[t] = 0;
          r.play_accepted = 1'b1;
          r.track_index = t[3:0];
        end
        mix_expected.push_back(r);
      end
      ACT_MIX: begin
        for (int c = 0; c < 8; c++) acc[c] = 0;
        for (t = 0; t < ntr; t++) begin
          if (act[t]) begin
            tc = chans[t];
            start = base[t] + tc * pos[t];
            for (int c = 0; c < nch; c++) acc[c] += sample_at(start + c % tc);
          end
        end
        // Advance every mixed track and free the finished ones
        for (t = 0; t < ntr; t++) begin
          if (act[t]) begin
            if (pos[t] + 1 >= len[t]) begin
              act[t] = 1'b0;
              pos[t] = 0;
            end else begin
              pos[t] = pos[t] + 1;
            end
          end
        end
        for (int c = 0; c < nch; c++) begin
          r = '0;
          r.kind = 1'b1;
          r.mixed_sample = (acc[c] > 32767) ? 16'sd32767 :
                           (acc[c] < -32768) ? -16'sd32768 : acc[c][15:0];
          r.channel_index = c[2:0];
          r.last_of_frame = (c + 1 == nch);
          mix_expected.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_word_t e;
    if (rst) begin
      chan_cfg <= 4'd2;
      trk_cfg <= 5'd16;
      for (int t = 0; t < MaxTracks; t++) begin
        act[t] = 1'b0; base[t] = 0; chans[t] = 1; len[t] = 0; pos[t] = 0;
      end
      mix_expected.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_OUT_CHANNELS) chan_cfg <= cfg_data[3:0];
        else trk_cfg <= cfg_data[4:0];
      end
      if (in_valid && !in_stall) predict_word(in_data);
      // Compare each accepted output word with the oldest prediction
      if (out_valid && !out_stall) begin
        if (mix_expected.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = mix_expected.pop_front();
          if (e !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected k%0d s%0d c%0d l%0d a%0d t%0d,",
                e.kind, e.mixed_sample, e.channel_index, e.last_of_frame,
                e.play_accepted, e.track_index,
                " got k%0d s%0d c%0d l%0d a%0d t%0d",
                out_data.kind, out_data.mixed_sample, out_data.channel_index,
                out_data.last_of_frame, out_data.play_accepted,
                out_data.track_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= mix_expected.size();
    end
  end
endmodule

[verif/tb_multi_voice_sample_mixer.sv]
// ---------------------------------------------------------------------------
// tb_multi_voice_sample_mixer
// Drives loads, plays and mixes through the sample mixer in phases of
// register settings, with bursty input and random output stall.
// ---------------------------------------------------------------------------
module tb_multi_voice_sample_mixer;
  import mvsm_pkg::*;

  localparam int InW = $bits(in_word_t);
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         burst_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multi_voice_sample_mixer dut (.*);
  mvsm_checker u_checker (.*);

  // Stall the receiver on its own pattern, with quiet stretches
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if ((cycles / 400) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
    if (cycles > 3000000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Hold valid across a burst; drop it only for a gap
  task automatic send_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (900) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_word_t load_word(logic [15:0] a, logic [15:0] v);
    in_word_t w;
    w = in_word_t'(InW'({$urandom, $urandom, $urandom}));
    w.action = ACT_LOAD;
    w.mem_addr = a;
    w.sample_value = v;
    return w;
  endfunction

  // Build a play word with the given base, channel count and frame count
  function automatic in_word_t play_word(logic [15:0] b, logic [3:0] ch,
                                         logic [15:0] fr);
    in_word_t w;
    w = in_word_t'(InW'({$urandom, $urandom, $urandom}));
    w.action = ACT_PLAY;
    w.sound_base = b;
    w.sound_channels = ch;
    w.sound_frames = fr;
    return w;
  endfunction

  function automatic in_word_t mix_word();
    in_word_t w;
    w = in_word_t'(InW'({$urandom, $urandom, $urandom}));
    w.action = ACT_MIX;
    return w;
  endfunction

  initial begin
    in_word_t w;
    logic [15:0] b;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Fill two regions: 0..95 and the top sixteen words, so wrapped reads stay written
    for (int a = 0; a < 96; a++) begin
      b = (a % 7 == 0) ? 16'h7fff : (a % 7 == 1) ? 16'h8000 : 16'($urandom);
      send_word(load_word(a[15:0], b));
    end
    for (int a = 65520; a < 65536; a++) send_word(load_word(a[15:0], 16'($urandom)));

    // Directed: mix empty, zero channels and frames, wrap, overflow, refusal, ignored
    send_word(mix_word());
    send_word(play_word(16'd0, 4'd0, 16'd0));
    send_word(play_word(16'hfff0, 4'd8, 16'd3));
    for (int i = 0; i < 14; i++) send_word(play_word(16'd0, 4'd1, 16'd2));
    send_word(play_word(16'd7, 4'd2, 16'd1));
    w = mix_word(); w.action = ACT_UNUSED; send_word(w);
    send_word(mix_word());
    send_word(mix_word());
    send_word(mix_word());

    // Phases across register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_OUT_CHANNELS, 8'd8); write_reg(REG_TRACKS, 8'd16); end
        1: begin write_reg(REG_OUT_CHANNELS, 8'd1); write_reg(REG_TRACKS, 8'd1); end
        2: begin write_reg(REG_OUT_CHANNELS, 8'd0); write_reg(REG_TRACKS, 8'd0); end
        3: begin write_reg(REG_OUT_CHANNELS, 8'd15); write_reg(REG_TRACKS, 8'd31); end
        4: begin write_reg(REG_OUT_CHANNELS, 8'd3); write_reg(REG_TRACKS, 8'd4); end
        default: begin
          write_reg(REG_OUT_CHANNELS, 8'($urandom));
          write_reg(REG_TRACKS, 8'($urandom));
        end
      endcase
      for (int i = 0; i < 11; i++) begin
        case ($urandom_range(0, 9))
          0: send_word(load_word(16'($urandom_range(0, 95)), 16'($urandom)));
          1, 2, 3: begin
            // Short sounds stay inside the low written region
            w = play_word(16'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                          16'($urandom_range(0, 8)));
            if (w.sound_channels > 8) w.sound_channels = 4'd1;
            // Long mono sounds start at the top and wrap into the low region
            if ($urandom_range(0, 9) == 0) begin
              w.sound_base = 16'hfff0;
              w.sound_channels = 4'd1;
              w.sound_frames = 16'hffff;
            end
            send_word(w);
          end
          4: begin w = mix_word(); w.action = ACT_UNUSED; send_word(w); end
          default: send_word(mix_word());
        endcase
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (900) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
